// ----- design/srmpc_pkg.sv -----
// Shared types and helpers for the sector range map path chooser.
// Holds the request codes, the register indexes, the item structs and the sector math.
// No dependencies.
package srmpc_pkg;

  localparam int unsigned SectorNum = 8;
  localparam int unsigned SectorW   = 3;
  localparam int unsigned DegW      = 9;
  localparam int unsigned RangeW    = 10;
  localparam int unsigned StepDeg   = 45;
  localparam int unsigned FullTurn  = 360;
  localparam int unsigned CfgIdxW   = 2;

  // Request codes; code 3 is unused and reports like a store that changes nothing
  typedef enum logic [1:0] {
    REQ_STORE  = 2'd0,
    REQ_CHOOSE = 2'd1,
    REQ_CHECK  = 2'd2
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_AHEAD = 2'd0,
    CFG_BLOCK_DIAG  = 2'd1,
    CFG_CLEAR_AHEAD = 2'd2,
    CFG_CLEAR_DIAG  = 2'd3
  } cfg_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DegW-1:0]   orientation;
    logic [DegW-1:0]   sensor_heading;
    logic [RangeW-1:0] range_inches;
    logic              force_new;
  } in_item_t;

  typedef struct packed {
    logic [DegW-1:0] direction;
    logic            path_found;
    logic            blocked_ahead;
    logic            blocked_diag;
    logic [DegW-1:0] rounded_heading;
    logic            at_target;
    logic            turn_right;
  } out_item_t;

  // Degrees 0..359 to the nearest sector, ties up, 360 wraps to sector 0
  function automatic logic [SectorW-1:0] deg_to_sector(input logic [DegW-1:0] deg);
    logic [DegW-1:0]  biased;
    logic [SectorW:0] cnt;
    biased = deg + DegW'((StepDeg - 1) / 2);
    cnt    = '0;
    for (int k = 1; k <= SectorNum; k++) begin
      if (biased >= DegW'(k * StepDeg)) begin
        cnt = cnt + 1'b1;
      end
    end
    return cnt[SectorW-1:0];
  endfunction

  function automatic logic [DegW-1:0] sector_to_deg(input logic [SectorW-1:0] s);
    return DegW'(s) * DegW'(StepDeg);
  endfunction

endpackage

// ----- design/sector_range_map_path_chooser.sv -----
// Top level of the sector range map path chooser: map, sequencer and result register.
// Depends on srmpc_pkg.
//
// The block keeps eight sector ranges and a travel sector. One item is taken at a
// time: a store item writes the map, a check or choose item reads it, and the result
// is then loaded into the output register; the next item is accepted in the cycle
// after the result is loaded at the earliest. A finished result may wait at the
// output while the next item is taken; the result after it holds the sequencer until
// the first one leaves. The length of each item is set by the single read port of the
// sector map: choose walks all eight sectors plus two wrap reads through the shared
// compare unit, check reads three sectors.
// The map comes out of reset cleared, no clearing pass is needed.
module sector_range_map_path_chooser
  import srmpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [RangeW-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_SCAN,
    ST_CHECK,
    ST_FIN
  } state_e;

  localparam logic [3:0] ScanLast  = 4'd9;
  localparam logic [3:0] CheckLast = 4'd2;

  state_e                         state_q;
  logic [3:0]                     cnt_q;
  logic [SectorW-1:0]             base_q;
  logic [SectorW-1:0]             travel_q;
  logic [SectorNum-1:0][RangeW-1:0] ranges_q;
  logic                           found_q;
  logic [SectorW-1:0]             best_q;
  logic [SectorW-1:0]             best_diff_q;
  logic                           qa1_q, qd1_q, qd2_q;
  logic                           ba_q, bd_q;
  logic [1:0]                     req_q;
  logic [DegW-1:0]                omod_q;
  logic [DegW-1:0]                sens_q;
  logic [RangeW-1:0]              range_q;
  logic                           force_q;
  logic                           out_valid_q;
  out_item_t                      out_data_q;

  logic [RangeW-1:0] block_ahead_q, block_diag_q, clear_ahead_q, clear_diag_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_ahead_q <= RangeW'(12);
      block_diag_q  <= RangeW'(10);
      clear_ahead_q <= RangeW'(15);
      clear_diag_q  <= RangeW'(12);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_AHEAD: block_ahead_q <= cfg_data_i;
        CFG_BLOCK_DIAG:  block_diag_q  <= cfg_data_i;
        CFG_CLEAR_AHEAD: clear_ahead_q <= cfg_data_i;
        CFG_CLEAR_DIAG:  clear_diag_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared read port and compare unit
  logic [SectorW-1:0] rd_addr;
  logic [RangeW-1:0]  rd_range;
  logic [RangeW:0]    thr_a, thr_b;
  logic               lt_a, lt_b;
  logic [SectorW-1:0] center, diff;
  logic               qual, take;
  logic [DegW-1:0]    omod_in;
  logic [RangeW-1:0]  head_sum;
  logic [DegW-1:0]    head_deg;
  logic [SectorW-1:0] store_sector;
  logic [SectorW-1:0] travel_next, rs;
  logic               fin_load;
  out_item_t          out_next;

  always_comb begin
    rd_addr  = base_q + cnt_q[SectorW-1:0];
    rd_range = ranges_q[rd_addr];
    if (req_q == REQ_CHECK) begin
      // blocked means range <= limit, i.e. range < limit + 1
      thr_a = {1'b0, block_ahead_q} + (RangeW + 1)'(1);
      thr_b = {1'b0, block_diag_q} + (RangeW + 1)'(1);
    end else begin
      thr_a = {1'b0, clear_ahead_q};
      thr_b = {1'b0, clear_diag_q};
    end
    lt_a = {1'b0, rd_range} < thr_a;
    lt_b = {1'b0, rd_range} < thr_b;

    // Candidate sits one read behind the current read
    center = cnt_q[SectorW-1:0] - SectorW'(2);
    diff   = (center > travel_q) ? center - travel_q : travel_q - center;
    qual   = qa1_q && qd2_q && !lt_b && !(force_q && center == travel_q);
    take   = qual && (cnt_q >= 4'd2) && (!found_q || diff < best_diff_q);

    omod_in = (in_data_i.orientation >= DegW'(FullTurn))
            ? in_data_i.orientation - DegW'(FullTurn) : in_data_i.orientation;

    head_sum = {1'b0, omod_q} + {1'b0, sens_q};
    if (head_sum >= RangeW'(2 * FullTurn)) begin
      head_deg = DegW'(head_sum - RangeW'(2 * FullTurn));
    end else if (head_sum >= RangeW'(FullTurn)) begin
      head_deg = DegW'(head_sum - RangeW'(FullTurn));
    end else begin
      head_deg = head_sum[DegW-1:0];
    end
    store_sector = deg_to_sector(head_deg);

    if (req_q == REQ_CHOOSE) begin
      travel_next = found_q ? best_q : travel_q + SectorW'(SectorNum / 2);
    end else begin
      travel_next = travel_q;
    end
    rs = deg_to_sector(omod_q);

    out_next.direction       = sector_to_deg(travel_next);
    out_next.path_found      = (req_q == REQ_CHOOSE) && found_q;
    out_next.blocked_ahead   = ba_q;
    out_next.blocked_diag    = bd_q;
    out_next.rounded_heading = sector_to_deg(rs);
    out_next.at_target       = (rs == travel_next);
    // More than half a turn the short way is the other side
    if (rs < travel_next) begin
      out_next.turn_right = !((travel_next - rs) > SectorW'(SectorNum / 2));
    end else begin
      out_next.turn_right = (rs - travel_next) > SectorW'(SectorNum / 2);
    end

    fin_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      base_q      <= '0;
      travel_q    <= '0;
      ranges_q    <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_diff_q <= '0;
      qa1_q       <= 1'b0;
      qd1_q       <= 1'b0;
      qd2_q       <= 1'b0;
      ba_q        <= 1'b0;
      bd_q        <= 1'b0;
      req_q       <= REQ_STORE;
      omod_q      <= '0;
      sens_q      <= '0;
      range_q     <= '0;
      force_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_data_i.req_type;
            omod_q  <= omod_in;
            sens_q  <= in_data_i.sensor_heading;
            range_q <= in_data_i.range_inches;
            force_q <= in_data_i.force_new;
            cnt_q   <= '0;
            found_q <= 1'b0;
            ba_q    <= 1'b0;
            bd_q    <= 1'b0;
            case (in_data_i.req_type)
              REQ_STORE: begin
                state_q <= ST_STORE;
              end
              REQ_CHOOSE: begin
                // start one sector early so sector 0 sees its left neighbor
                base_q  <= SectorW'(SectorNum - 1);
                state_q <= ST_SCAN;
              end
              REQ_CHECK: begin
                base_q  <= travel_q - SectorW'(1);
                state_q <= ST_CHECK;
              end
              default: begin
                state_q <= ST_FIN;
              end
            endcase
          end
        end
        ST_STORE: begin
          ranges_q[store_sector] <= range_q;
          state_q                <= ST_FIN;
        end
        ST_SCAN: begin
          qa1_q <= !lt_a;
          qd1_q <= !lt_b;
          qd2_q <= qd1_q;
          if (take) begin
            found_q     <= 1'b1;
            best_q      <= center;
            best_diff_q <= diff;
          end
          if (cnt_q == ScanLast) begin
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_CHECK: begin
          // left, ahead, right in that order
          if (cnt_q == 4'd1) begin
            ba_q <= lt_a;
          end else if (lt_b) begin
            bd_q <= 1'b1;
          end
          if (cnt_q == CheckLast) begin
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (fin_load) begin
            out_data_q <= out_next;
            travel_q   <= travel_next;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_travel_only_on_choose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(travel_q) |-> $past(fin_load) && $past(req_q) == REQ_CHOOSE)
    else $error("travel sector changed outside a choose transaction");

  a_map_only_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(ranges_q) |-> $past(state_q) == ST_STORE)
    else $error("sector map written outside a store transaction");

  a_found_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(found_q) |-> $past(state_q) == ST_SCAN)
    else $error("path found flag set outside the scan");

  a_flags_only_on_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load && req_q != REQ_CHECK |=>
      !out_data_q.blocked_ahead && !out_data_q.blocked_diag)
    else $error("blocked flag reported on a non-check transaction");

endmodule
